// File: rtl/core/lkv_pkg.sv
// lkv_pkg: shared types and constants for the linear key/value table
// beat payload structs, search token carried down the cell chain
// no dependencies
package lkv_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CMP_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } lkv_func_e;

  typedef struct packed {
    lkv_func_e        func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] write_value;
  } lkv_req_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] read_value;
  } lkv_rsp_t;

  typedef struct packed {
    logic             active;
    lkv_func_e        func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] wval;
    logic             found;
    logic [VAL_W-1:0] value;
  } lkv_tok_t;

endpackage

// File: rtl/core/lkv_cell.sv
// lkv_cell: one table entry plus one stage of the search chain
// compares the passing token, updates or reads its entry, registers the token onward
// depends on lkv_pkg
module lkv_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lkv_pkg::lkv_tok_t        tok_i,
  output lkv_pkg::lkv_tok_t        tok_o,
  input  logic [CNT_W-1:0]         count_i,
  input  logic                     app_we_i,
  input  logic [lkv_pkg::KEY_W-1:0] app_key_i,
  input  logic [lkv_pkg::VAL_W-1:0] app_val_i
);
  import lkv_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  lkv_tok_t         tok_q, tok_d;
  logic             live;
  logic             hit;
  logic             app_here;

  assign live     = (INDEX < DEPTH) && (CNT_W'(INDEX) < count_i);
  assign hit      = tok_i.active && !tok_i.found && live && (key_q == tok_i.key);
  assign app_here = app_we_i && (count_i == CNT_W'(INDEX));

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      if (tok_i.func == FUNC_LOOKUP) begin
        tok_d.value = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (app_here) begin
      key_q <= app_key_i;
      val_q <= app_val_i;
    end else if (hit && tok_i.func == FUNC_INSERT) begin
      val_q <= tok_i.wval;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/linear_key_value_table_core.sv
// linear_key_value_table_core: key/value table of configurable capacity (at most DEPTH), chain of DEPTH cells
// an accepted request is registered as the head token and again by each cell in turn;
// the done strobe and response are registered from the tail; busy refuses new requests
// until done; the receiver cannot stall; reset empties the table and sets capacity to 16
// depends on lkv_pkg, lkv_cell
module linear_key_value_table_core #(
  parameter int unsigned DEPTH = lkv_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  lkv_pkg::lkv_req_t         req_i,
  input  logic                      cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output lkv_pkg::lkv_rsp_t         rsp_o
);
  import lkv_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lkv_tok_t         chain [DEPTH+1];
  lkv_tok_t         head_q, head_d;
  lkv_tok_t         tail;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  lkv_rsp_t         rsp_q, rsp_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic [CMP_W-1:0] lim;
  logic             can_app;
  logic             accept;
  logic             app_we;

  assign accept  = start && !busy_q;
  assign chain[0] = head_q;
  assign tail    = chain[DEPTH];

  assign lim     = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign can_app = CMP_W'(count_q) < lim;
  assign app_we  = tail.active && !tail.found && (tail.func == FUNC_INSERT) && can_app;

  always_comb begin
    head_d        = head_q;
    head_d.active = 1'b0;
    busy_d        = busy_q;
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    count_d       = count_q;
    if (accept) begin
      head_d.active = 1'b1;
      head_d.func   = req_i.func;
      head_d.key    = req_i.key;
      head_d.wval   = req_i.write_value;
      head_d.found  = 1'b0;
      head_d.value  = '0;
      busy_d        = 1'b1;
    end
    if (tail.active) begin
      busy_d           = 1'b0;
      done_d           = 1'b1;
      rsp_d.ok         = tail.found || app_we;
      rsp_d.read_value = tail.value;
      if (app_we) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      head_q  <= head_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lkv_cell #(
      .DEPTH (DEPTH),
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1]),
      .count_i   (count_q),
      .app_we_i  (app_we),
      .app_key_i (tail.key),
      .app_val_i (tail.wval)
    );
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
